// ----- design/tcm_pkg.sv -----
// Shared types, constants and character helpers for the token classifier.
package tcm_pkg;

   // Word and counter limits
   localparam int MAX_WORD   = 32;
   localparam int COUNT_BITS = 16;
   localparam int LEN_W      = 6;
   localparam int KW_N       = 9;
   localparam int KW_W       = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD);

   // Token class codes
   localparam logic [2:0] CLS_KEYWORD    = 3'd0;
   localparam logic [2:0] CLS_IDENTIFIER = 3'd1;
   localparam logic [2:0] CLS_OPERATOR   = 3'd2;
   localparam logic [2:0] CLS_SPECIAL    = 3'd3;
   localparam logic [2:0] CLS_DIGIT      = 3'd4;

   // Keyword text, first character in the top byte, zero padded
   localparam logic [8*KW_W-1:0] KW_TEXT [KW_N] = '{
      {"int",     40'h0},
      {"main",    32'h0},
      {"if",      48'h0},
      {"else",    32'h0},
      {"do",      48'h0},
      {"while",   24'h0},
      {"include",  8'h0},
      {"printf",  16'h0},
      {"void",    32'h0}
   };

   localparam logic [3:0] KW_LEN [KW_N] = '{
      4'd3, 4'd4, 4'd2, 4'd4, 4'd2, 4'd5, 4'd7, 4'd6, 4'd4
   };

   // One queued request: an optional finished word followed by an optional symbol
   typedef struct packed {
      logic             has_word;
      logic             word_kw;
      logic [3:0]       kw_idx;
      logic [LEN_W-1:0] word_len;
      logic             word_trunc;
      logic             has_sym;
      logic [2:0]       sym_cls;
      logic [7:0]       sym;
   } tok_entry_type;

   function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
      logic [8*KW_W-1:0] txt;
      txt = KW_TEXT[k];
      return txt[8*KW_W-1 - 8*pos -: 8];
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_oper(input logic [7:0] b);
      return b == "+" || b == "-" || b == "*" || b == "/" || b == "=";
   endfunction

   function automatic logic is_special(input logic [7:0] b);
      return b == ";" || b == "{" || b == "}" || b == "(" || b == ")" ||
             b == "?" || b == "@" || b == "!" || b == "%";
   endfunction

endpackage

// ----- design/tcm_front.sv -----
// Front end: tracks the current word, matches keywords and classifies each byte.
module tcm_front import tcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    in_byte,
   input  logic          end_of_input,
   output tok_entry_type entry,
   output logic          entry_valid
);

   logic             in_word_ff, in_word_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [KW_N-1:0]  alive_ff, alive_in;

   logic             alnum;
   logic [KW_N-1:0]  match_cur, match_first;
   logic             hit;
   logic [3:0]       hit_idx;

   // Per-keyword compare of this byte at the current position and at position zero
   always_comb begin
      for (int k = 0; k < KW_N; k++) begin
         match_cur[k]   = (len_ff < LEN_W'(KW_W)) && (kw_char(k, len_ff[2:0]) == in_byte);
         match_first[k] = (kw_char(k, 3'd0) == in_byte);
      end
   end

   // Lowest live keyword whose length equals the word length
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = KW_N-1; k >= 0; k--) begin
         if (alive_ff[k] && ({2'b00, KW_LEN[k]} == len_ff)) begin
            hit     = 1'b1;
            hit_idx = 4'(k);
         end
      end
      if (ovf_ff) begin
         hit = 1'b0;
      end
   end

   // Classification and next word state
   always_comb begin
      alnum      = is_alpha(in_byte) || is_digit(in_byte);
      in_word_in = in_word_ff;
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      alive_in   = alive_ff;

      entry            = '0;
      entry.word_kw    = hit;
      entry.kw_idx     = hit ? hit_idx : 4'd0;
      entry.word_len   = len_ff;
      entry.word_trunc = hit ? 1'b0 : ovf_ff;

      if (end_of_input) begin
         entry.has_word = in_word_ff;
         in_word_in     = 1'b0;
      end else if (in_word_ff && alnum) begin
         alive_in = alive_ff & match_cur;
         if (len_ff < MAX_LEN) begin
            len_in = len_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end else begin
         entry.has_word = in_word_ff;
         in_word_in     = 1'b0;
         entry.sym      = in_byte;
         if (is_oper(in_byte)) begin
            entry.has_sym = 1'b1;
            entry.sym_cls = CLS_OPERATOR;
         end else if (is_special(in_byte)) begin
            entry.has_sym = 1'b1;
            entry.sym_cls = CLS_SPECIAL;
         end else if (is_digit(in_byte)) begin
            entry.has_sym = 1'b1;
            entry.sym_cls = CLS_DIGIT;
         end else if (is_alpha(in_byte)) begin
            in_word_in = 1'b1;
            len_in     = LEN_W'(1);
            ovf_in     = 1'b0;
            alive_in   = match_first;
         end
      end

      // A finished word always leaves a fresh keyword set behind
      if (!in_word_in) begin
         len_in   = '0;
         ovf_in   = 1'b0;
         alive_in = '1;
      end
   end

   assign entry_valid = accept && (entry.has_word || entry.has_sym);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         alive_ff   <= '1;
      end else if (accept) begin
         in_word_ff <= in_word_in;
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         alive_ff   <= alive_in;
      end
   end

endmodule

// ----- design/tcm_queue.sv -----
// Short request queue between the front end and the back end.
module tcm_queue import tcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  tok_entry_type wr_data,
   output logic          q_full,
   input  logic          rd_en,
   output tok_entry_type rd_data,
   output logic          rd_valid
);

   tok_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;

   assign q_full   = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = slot_ff[rptr_ff];

   // Pointer and fill count update
   always_comb begin
      wptr_in = wr_en ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = rd_en ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/tcm_back.sv -----
// Back end: expands queued requests into tokens, keeps class totals, holds the result.
module tcm_back import tcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tok_entry_type head,
   input  logic          head_valid,
   output logic          head_pop,
   input  logic          pop,
   output logic          empty,
   output logic [2:0]    token_class,
   output logic [7:0]    symbol,
   output logic [3:0]    keyword_index,
   output logic [5:0]    word_length,
   output logic          word_truncated,
   output logic          last_of_run,
   output logic [15:0]   keyword_count,
   output logic [15:0]   identifier_count,
   output logic [15:0]   operator_count,
   output logic [15:0]   special_count,
   output logic [15:0]   digit_count
);

   typedef logic [COUNT_BITS-1:0] cnt_type;

   logic        out_valid_ff;
   logic        phase_ff, phase_in;
   cnt_type     kw_ff, id_ff, op_ff, sp_ff, dg_ff;
   cnt_type     kw_in, id_in, op_in, sp_in, dg_in;
   logic [2:0]  cls_ff, cls_in;
   logic [7:0]  sym_ff, sym_in;
   logic [3:0]  kidx_ff, kidx_in;
   logic [5:0]  len_ff, len_in;
   logic        trunc_ff, trunc_in;
   logic        last_ff, last_in;
   logic        load;
   logic        emit_word;

   function automatic cnt_type sat_inc(input cnt_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // Select the next token from the queue head
   always_comb begin
      load      = (!out_valid_ff || pop) && head_valid;
      emit_word = head.has_word && !phase_ff;
      head_pop  = load && (!emit_word || !head.has_sym);

      phase_in = phase_ff;
      if (load) begin
         phase_in = emit_word && head.has_sym;
      end

      kw_in = kw_ff;
      id_in = id_ff;
      op_in = op_ff;
      sp_in = sp_ff;
      dg_in = dg_ff;
      if (emit_word) begin
         cls_in   = head.word_kw ? CLS_KEYWORD : CLS_IDENTIFIER;
         sym_in   = '0;
         kidx_in  = head.kw_idx;
         len_in   = head.word_len;
         trunc_in = head.word_trunc;
         last_in  = !head.has_sym;
      end else begin
         cls_in   = head.sym_cls;
         sym_in   = head.sym;
         kidx_in  = '0;
         len_in   = '0;
         trunc_in = 1'b0;
         last_in  = 1'b1;
      end

      case (cls_in)
         CLS_KEYWORD:    kw_in = sat_inc(kw_ff);
         CLS_IDENTIFIER: id_in = sat_inc(id_ff);
         CLS_OPERATOR:   op_in = sat_inc(op_ff);
         CLS_SPECIAL:    sp_in = sat_inc(sp_ff);
         CLS_DIGIT:      dg_in = sat_inc(dg_ff);
         default:        kw_in = kw_ff;
      endcase
   end

   // Control state and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         kw_ff        <= '0;
         id_ff        <= '0;
         op_ff        <= '0;
         sp_ff        <= '0;
         dg_ff        <= '0;
      end else begin
         phase_ff <= phase_in;
         if (load) begin
            out_valid_ff <= 1'b1;
            kw_ff        <= kw_in;
            id_ff        <= id_in;
            op_ff        <= op_in;
            sp_ff        <= sp_in;
            dg_ff        <= dg_in;
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         cls_ff   <= cls_in;
         sym_ff   <= sym_in;
         kidx_ff  <= kidx_in;
         len_ff   <= len_in;
         trunc_ff <= trunc_in;
         last_ff  <= last_in;
      end
   end

   assign empty            = !out_valid_ff;
   assign token_class      = cls_ff;
   assign symbol           = sym_ff;
   assign keyword_index    = kidx_ff;
   assign word_length      = len_ff;
   assign word_truncated   = trunc_ff;
   assign last_of_run      = last_ff;
   assign keyword_count    = kw_ff;
   assign identifier_count = id_ff;
   assign operator_count   = op_ff;
   assign special_count    = sp_ff;
   assign digit_count      = dg_ff;

endmodule

// ----- design/token_classifier_with_keyword_match.sv -----
// Top level of the token classifier with keyword match.
//
// Input side is a queue write port: drive req_in_byte / req_end_of_input and
// raise push; the byte is taken on a clock edge where full is low. One byte a
// cycle is accepted while the internal request queue has room.
// Result side is a queue read port: while empty is low the oldest token sits on
// the rsp_ ports; raising pop takes it at the clock edge.
// A byte that finishes a word and is itself a token gives two results; the
// word comes first and only the final one carries rsp_last_of_run.
// The queue is written at the edge that accepts a byte; the result register
// loads from the queue head whenever it is empty or being popped. Throughput:
// one result per cycle from the back end while the receiver pops, so bytes giving
// one or no token stream at one per cycle; a byte giving two tokens holds the
// queue head until both are out, and the four-entry queue absorbs the extra result.
// When the receiver stalls, the result register holds, the queue fills and
// full rises; nothing is dropped. Synchronous reset clears the word tracker,
// the queue, the result valid flag and all class totals.
module token_classifier_with_keyword_match import tcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_token_class,
   output logic [7:0]  rsp_symbol,
   output logic [3:0]  rsp_keyword_index,
   output logic [5:0]  rsp_word_length,
   output logic        rsp_word_truncated,
   output logic        rsp_last_of_run,
   output logic [15:0] rsp_keyword_count,
   output logic [15:0] rsp_identifier_count,
   output logic [15:0] rsp_operator_count,
   output logic [15:0] rsp_special_count,
   output logic [15:0] rsp_digit_count
);

   tok_entry_type front_entry;
   logic          front_valid;
   tok_entry_type head;
   logic          head_valid;
   logic          head_pop;
   logic          q_full;
   logic          accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   tcm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .entry        (front_entry),
      .entry_valid  (front_valid)
   );

   tcm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_valid),
      .wr_data  (front_entry),
      .q_full   (q_full),
      .rd_en    (head_pop),
      .rd_data  (head),
      .rd_valid (head_valid)
   );

   tcm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .pop              (pop),
      .empty            (empty),
      .token_class      (rsp_token_class),
      .symbol           (rsp_symbol),
      .keyword_index    (rsp_keyword_index),
      .word_length      (rsp_word_length),
      .word_truncated   (rsp_word_truncated),
      .last_of_run      (rsp_last_of_run),
      .keyword_count    (rsp_keyword_count),
      .identifier_count (rsp_identifier_count),
      .operator_count   (rsp_operator_count),
      .special_count    (rsp_special_count),
      .digit_count      (rsp_digit_count)
   );

endmodule

// ----- sim/tcm_token_check.sv -----
`timescale 1ns / 100ps
// Token checker: watches both channels, predicts the tokens of each request and compares.
module tcm_token_check import tcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   input  logic        empty,
   input  logic        pop,
   input  logic [2:0]  rsp_token_class,
   input  logic [7:0]  rsp_symbol,
   input  logic [3:0]  rsp_keyword_index,
   input  logic [5:0]  rsp_word_length,
   input  logic        rsp_word_truncated,
   input  logic        rsp_last_of_run,
   input  logic [15:0] rsp_keyword_count,
   input  logic [15:0] rsp_identifier_count,
   input  logic [15:0] rsp_operator_count,
   input  logic [15:0] rsp_special_count,
   input  logic [15:0] rsp_digit_count,
   output int          mismatches,
   output int          outstanding
);

   typedef struct packed {
      logic [2:0]  cls;
      logic [7:0]  sym;
      logic [3:0]  kidx;
      logic [5:0]  len;
      logic        trunc;
      logic        last;
      logic [15:0] n_kw;
      logic [15:0] n_id;
      logic [15:0] n_op;
      logic [15:0] n_sp;
      logic [15:0] n_dg;
   } token_type;

   typedef enum logic [2:0] {
      KIND_LETTER, KIND_NUMERAL, KIND_OPER, KIND_SPECIAL, KIND_OTHER
   } char_kind_type;

   // keyword spellings, right-justified and zero padded, in table order
   localparam logic [63:0] KEYWORD_TEXT [KW_N] = '{
      "int", "main", "if", "else", "do", "while", "include", "printf", "void"
   };

   // word tracker and class totals
   logic        in_word;
   int          word_len;
   logic        word_over;
   logic [63:0] word_bits;
   logic [15:0] kw_seen, id_seen, op_seen, sp_seen, dg_seen;

   token_type tokens_due [$];
   token_type step_tokens [2];
   int        step_n;

   function automatic char_kind_type kind_of(input logic [7:0] ch);
      case (ch)
         "+", "-", "*", "/", "=":                     return KIND_OPER;
         ";", "{", "}", "(", ")", "?", "@", "!", "%": return KIND_SPECIAL;
         default: begin
            if (ch >= "0" && ch <= "9")
               return KIND_NUMERAL;
            if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))
               return KIND_LETTER;
            return KIND_OTHER;
         end
      endcase
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   task automatic flag_token(input string msg);
      mismatches++;
      $display("%0t: %s", $time, msg);
   endtask

   // bump the class total, then record the token with the totals after the bump
   task automatic add_token(input logic [2:0] cls, input logic [7:0] sym,
                            input logic [3:0] kidx, input int len, input logic trunc);
      token_type t;
      case (cls)
         CLS_KEYWORD:    kw_seen = sat_inc(kw_seen);
         CLS_IDENTIFIER: id_seen = sat_inc(id_seen);
         CLS_OPERATOR:   op_seen = sat_inc(op_seen);
         CLS_SPECIAL:    sp_seen = sat_inc(sp_seen);
         default:        dg_seen = sat_inc(dg_seen);
      endcase
      t.cls   = cls;
      t.sym   = sym;
      t.kidx  = kidx;
      t.len   = 6'(len);
      t.trunc = trunc;
      t.last  = 1'b0;
      t.n_kw  = kw_seen;
      t.n_id  = id_seen;
      t.n_op  = op_seen;
      t.n_sp  = sp_seen;
      t.n_dg  = dg_seen;
      step_tokens[step_n] = t;
      step_n++;
   endtask

   // emit the pending word as keyword or identifier and clear the tracker
   task automatic close_word();
      int hit;
      hit = -1;
      if (!word_over && word_len <= 8)
         for (int k = 0; k < KW_N; k++)
            if (hit < 0 && word_bits == KEYWORD_TEXT[k])
               hit = k;
      if (hit >= 0)
         add_token(CLS_KEYWORD, 8'd0, 4'(hit), word_len, 1'b0);
      else
         add_token(CLS_IDENTIFIER, 8'd0, 4'd0, word_len, word_over);
      in_word   = 1'b0;
      word_len  = 0;
      word_over = 1'b0;
      word_bits = '0;
   endtask

   // predict the tokens caused by one accepted request
   task automatic classify_byte(input logic [7:0] ch, input logic eoi);
      char_kind_type kind;
      token_type     t;
      kind   = kind_of(ch);
      step_n = 0;
      if (eoi) begin
         if (in_word)
            close_word();
      end else if (in_word && (kind == KIND_LETTER || kind == KIND_NUMERAL)) begin
         // only the first eight characters can decide a keyword
         if (word_len < 8)
            word_bits = {word_bits[55:0], ch};
         if (word_len < MAX_WORD)
            word_len++;
         else
            word_over = 1'b1;
      end else begin
         if (in_word)
            close_word();
         case (kind)
            KIND_OPER:    add_token(CLS_OPERATOR, ch, 4'd0, 0, 1'b0);
            KIND_SPECIAL: add_token(CLS_SPECIAL, ch, 4'd0, 0, 1'b0);
            KIND_NUMERAL: add_token(CLS_DIGIT, ch, 4'd0, 0, 1'b0);
            KIND_LETTER: begin
               in_word   = 1'b1;
               word_len  = 1;
               word_over = 1'b0;
               word_bits = {56'd0, ch};
            end
            default: ;
         endcase
      end
      for (int i = 0; i < step_n; i++) begin
         t = step_tokens[i];
         t.last = (i == step_n - 1);
         tokens_due.push_back(t);
      end
   endtask

   // compare one accepted token with the oldest prediction
   task automatic check_token();
      token_type want;
      string     bad;
      if (tokens_due.size() == 0) begin
         flag_token("token popped with no request pending");
         return;
      end
      want = tokens_due.pop_front();
      bad  = "";
      if (rsp_token_class !== want.cls)
         bad = {bad, $sformatf(" class %0d/%0d", rsp_token_class, want.cls)};
      if (rsp_symbol !== want.sym)
         bad = {bad, $sformatf(" symbol %h/%h", rsp_symbol, want.sym)};
      if (rsp_keyword_index !== want.kidx)
         bad = {bad, $sformatf(" kw_index %0d/%0d", rsp_keyword_index, want.kidx)};
      if (rsp_word_length !== want.len)
         bad = {bad, $sformatf(" length %0d/%0d", rsp_word_length, want.len)};
      if (rsp_word_truncated !== want.trunc)
         bad = {bad, $sformatf(" truncated %b/%b", rsp_word_truncated, want.trunc)};
      if (rsp_last_of_run !== want.last)
         bad = {bad, $sformatf(" last %b/%b", rsp_last_of_run, want.last)};
      if (rsp_keyword_count !== want.n_kw)
         bad = {bad, $sformatf(" kw_count %0d/%0d", rsp_keyword_count, want.n_kw)};
      if (rsp_identifier_count !== want.n_id)
         bad = {bad, $sformatf(" id_count %0d/%0d", rsp_identifier_count, want.n_id)};
      if (rsp_operator_count !== want.n_op)
         bad = {bad, $sformatf(" op_count %0d/%0d", rsp_operator_count, want.n_op)};
      if (rsp_special_count !== want.n_sp)
         bad = {bad, $sformatf(" sp_count %0d/%0d", rsp_special_count, want.n_sp)};
      if (rsp_digit_count !== want.n_dg)
         bad = {bad, $sformatf(" digit_count %0d/%0d", rsp_digit_count, want.n_dg)};
      if (bad != "")
         flag_token({"token mismatch (got/want):", bad});
   endtask

   // sample both handshakes at the clock edge; tokens leave before new ones are predicted
   always @(posedge clock) begin
      if (reset) begin
         in_word   = 1'b0;
         word_len  = 0;
         word_over = 1'b0;
         word_bits = '0;
         kw_seen   = '0;
         id_seen   = '0;
         op_seen   = '0;
         sp_seen   = '0;
         dg_seen   = '0;
         tokens_due.delete();
      end else begin
         if (!empty && pop)
            check_token();
         if (push && !full)
            classify_byte(req_in_byte, req_end_of_input);
      end
      outstanding <= tokens_due.size();
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, byte requests, pop pacing and the final verdict.
module tb;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_in_byte;
   logic        req_end_of_input;
   logic        empty;
   logic        pop;
   logic [2:0]  rsp_token_class;
   logic [7:0]  rsp_symbol;
   logic [3:0]  rsp_keyword_index;
   logic [5:0]  rsp_word_length;
   logic        rsp_word_truncated;
   logic        rsp_last_of_run;
   logic [15:0] rsp_keyword_count;
   logic [15:0] rsp_identifier_count;
   logic [15:0] rsp_operator_count;
   logic [15:0] rsp_special_count;
   logic [15:0] rsp_digit_count;

   int mismatches;
   int outstanding;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;

   // operators and specials, one byte each
   localparam logic [8*14-1:0] SYMBOLS = "+-*/=;{}()?@!%";

   token_classifier_with_keyword_match dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_in_byte          (req_in_byte),
      .req_end_of_input     (req_end_of_input),
      .empty                (empty),
      .pop                  (pop),
      .rsp_token_class      (rsp_token_class),
      .rsp_symbol           (rsp_symbol),
      .rsp_keyword_index    (rsp_keyword_index),
      .rsp_word_length      (rsp_word_length),
      .rsp_word_truncated   (rsp_word_truncated),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_keyword_count    (rsp_keyword_count),
      .rsp_identifier_count (rsp_identifier_count),
      .rsp_operator_count   (rsp_operator_count),
      .rsp_special_count    (rsp_special_count),
      .rsp_digit_count      (rsp_digit_count)
   );

   tcm_token_check watch (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_in_byte          (req_in_byte),
      .req_end_of_input     (req_end_of_input),
      .empty                (empty),
      .pop                  (pop),
      .rsp_token_class      (rsp_token_class),
      .rsp_symbol           (rsp_symbol),
      .rsp_keyword_index    (rsp_keyword_index),
      .rsp_word_length      (rsp_word_length),
      .rsp_word_truncated   (rsp_word_truncated),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_keyword_count    (rsp_keyword_count),
      .rsp_identifier_count (rsp_identifier_count),
      .rsp_operator_count   (rsp_operator_count),
      .rsp_special_count    (rsp_special_count),
      .rsp_digit_count      (rsp_digit_count),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // token side: pop at random per the current stall rate
   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   // one request: optional idle cycles, then hold until accepted
   task automatic send_item(input logic [7:0] ch, input logic eoi);
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_in_byte      <= ch;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (full)
         @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_symbol();
      return SYMBOLS[8 * $urandom_range(13) +: 8];
   endfunction

   function automatic logic [7:0] pick_word_char();
      case ($urandom_range(3))
         0:       return 8'($urandom_range("0", "9"));
         1:       return 8'($urandom_range("A", "Z"));
         default: return 8'($urandom_range("a", "z"));
      endcase
   endfunction

   function automatic string keyword_word(input int k);
      case (k)
         0:       return "int";
         1:       return "main";
         2:       return "if";
         3:       return "else";
         4:       return "do";
         5:       return "while";
         6:       return "include";
         7:       return "printf";
         default: return "void";
      endcase
   endfunction

   // something that ends a word: a symbol, white space, end of input or any byte
   task automatic end_word();
      case ($urandom_range(9))
         5:       send_item(" ", 1'b0);
         6:       send_item(8'($urandom_range(255)), 1'b1);
         7:       send_item(8'($urandom_range(255)), 1'b0);
         8:       send_item("\n", 1'b0);
         default: send_item(pick_symbol(), 1'b0);
      endcase
   endtask

   // mostly keywords and identifiers with terminators, plus symbols, digits and noise
   task automatic random_phase(input int tx_pct, input int rx_pct, input int quota);
      int    counted;
      int    pick;
      int    len;
      int    mode;
      string kw;
      logic [7:0] ch;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      counted = 0;
      while (counted < quota) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // keyword, sometimes with a near miss: extra char, cut short, capitalized
            kw   = keyword_word($urandom_range(8));
            mode = $urandom_range(5);
            len  = (mode == 2) ? kw.len() - 1 : kw.len();
            for (int i = 0; i < len; i++) begin
               ch = kw[i];
               if (i == 0 && mode == 3)
                  ch = ch - 8'd32;
               send_item(ch, 1'b0);
            end
            if (mode == 1)
               send_item(pick_word_char(), 1'b0);
            end_word();
            counted += len + 2;
         end else if (pick < 50) begin
            // identifier, a few of them around and past the length limit
            len = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
            send_item(($urandom_range(1) != 0) ? 8'($urandom_range("a", "z"))
                                               : 8'($urandom_range("A", "Z")), 1'b0);
            for (int i = 1; i < len; i++)
               send_item(pick_word_char(), 1'b0);
            end_word();
            counted += len + 1;
         end else if (pick < 70) begin
            send_item(pick_symbol(), 1'b0);
            counted++;
         end else if (pick < 80) begin
            send_item(8'($urandom_range("0", "9")), 1'b0);
            counted++;
         end else if (pick < 92) begin
            send_item(8'($urandom_range(255)), 1'b0);
         end else begin
            send_item(8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   initial begin
      int waited;
      reset            = 1'b1;
      push             = 1'b0;
      req_in_byte      = 8'd0;
      req_end_of_input = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: flush by end of input, word then symbol, ignored bytes, extremes
      tx_idle_pct = 8;
      rx_idle_pct = 71;
      send_text("int");
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b1);
      send_text("x9+");
      send_text("do(");
      send_text("Z7 ");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_text("5;%=");

      random_phase(8, 71, 150);
      random_phase(71, 8, 150);
      random_phase(0, 0, 150);
      push <= 1'b0;

      // drain, then allow a few cycles for anything unexpected
      waited = 0;
      repeat (2) @(posedge clock);
      while (outstanding != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
